### design/aee_pkg.sv
// ----------------------------------------------------------------------------
// aee_pkg
// Shared types and constants for the automation envelope evaluator.
// ----------------------------------------------------------------------------
package aee_pkg;

    localparam int MAX_POINTS = 256;
    localparam int TIME_BITS  = 48;
    localparam int IDX_BITS   = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
    localparam int VAL_BITS   = 17;
    localparam int QDEPTH     = 2;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_EVAL   = 2'd2;

    localparam logic [2:0] KIND_FADER = 3'd0;
    localparam logic [2:0] KIND_PAN   = 3'd1;
    localparam logic [2:0] KIND_MUTE  = 3'd2;
    localparam logic [2:0] KIND_SOLO  = 3'd3;

    localparam logic [2:0] REG_FADER_MIN = 3'd0;
    localparam logic [2:0] REG_FADER_MAX = 3'd1;
    localparam logic [2:0] REG_AUX_MIN   = 3'd2;
    localparam logic [2:0] REG_AUX_MAX   = 3'd3;
    localparam logic [2:0] REG_AUX_OFF   = 3'd4;

    // classified beat passed from the front to the back
    typedef struct packed {
        logic [1:0]           cmd;
        logic [TIME_BITS-1:0] ptime;
        logic [VAL_BITS-1:0]  pval;
        logic [TIME_BITS-1:0] qtime;
        logic [2:0]           kind;
    } t_job;

endpackage

### design/aee_front.sv
// ----------------------------------------------------------------------------
// aee_front
// Input stage and job queue: takes beats and queues them for the back end.
// ----------------------------------------------------------------------------
module aee_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  aee_pkg::t_job   i_job,
    output logic            o_job_valid,
    input  logic            i_job_ready,
    output aee_pkg::t_job   o_job
);
    import aee_pkg::*;

    localparam int PB = $clog2(QDEPTH);

    t_job            r_q [QDEPTH];
    logic [PB-1:0]   r_wp, r_rp;
    logic [PB:0]     r_cnt;
    logic            push, pop;

    assign o_ready     = (r_cnt != (PB+1)'(QDEPTH));
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rp];
    assign push        = i_valid && o_ready;
    assign pop         = o_job_valid && i_job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_q[r_wp] <= i_job;
                r_wp      <= r_wp + 1'b1;
            end
            if (pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PB+1)'(push) - (PB+1)'(pop);
        end
    end
endmodule

### design/aee_back.sv
// ----------------------------------------------------------------------------
// aee_back
// Executes jobs: table store, binary search, division, interpolation, mapping.
// ----------------------------------------------------------------------------
module aee_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    output logic                o_job_ready,
    input  aee_pkg::t_job       i_job,
    input  logic signed [15:0]  i_fmin,
    input  logic signed [15:0]  i_fmax,
    input  logic signed [15:0]  i_amin,
    input  logic signed [15:0]  i_amax,
    input  logic signed [15:0]  i_aoff,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [15:0]  o_level,
    output logic                o_table_full,
    output logic                o_table_empty
);
    import aee_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RDL, S_CHK, S_SRCH, S_SRCHW, S_PAIR, S_PAIRW,
        S_DIV, S_MUL, S_INT, S_MAP, S_MAPW, S_OUT
    } t_state;

    logic [TIME_BITS-1:0] r_tmem [MAX_POINTS];
    logic [VAL_BITS-1:0]  r_vmem [MAX_POINTS];
    logic [TIME_BITS-1:0] r_rt;
    logic [VAL_BITS-1:0]  r_rv;
    logic [IDX_BITS-1:0]  rd_addr;
    logic                 wr_en;
    logic [IDX_BITS-1:0]  wr_addr;
    logic [TIME_BITS-1:0] wr_t;

    t_state               r_state;
    t_job                 r_job;
    logic [CNT_BITS-1:0]  r_count;
    logic [TIME_BITS-1:0] r_last;
    logic [CNT_BITS-1:0]  r_lo, r_hi;
    logic [IDX_BITS-1:0]  r_addr;
    logic [TIME_BITS-1:0] r_t0, r_tlo;
    logic [VAL_BITS-1:0]  r_v0, r_vlo;
    logic                 r_first;
    logic [TIME_BITS:0]   r_rem;
    logic [TIME_BITS-1:0] r_den;
    logic [15:0]          r_f;
    logic [4:0]           r_it;
    logic signed [35:0]   r_prod;
    logic [VAL_BITS-1:0]  r_v;
    logic signed [17:0]   r_diff;
    logic signed [16:0]   r_a;
    logic signed [34:0]   r_macc;
    logic                 r_valid, r_full, r_empty;
    logic signed [15:0]   r_level;

    logic [CNT_BITS-1:0]  mid;
    logic [TIME_BITS:0]   rsh;
    logic signed [36:0]   acc;
    logic signed [16:0]   ma, mb;
    logic signed [40:0]   macc_full;

    assign mid = CNT_BITS'((r_lo + r_hi) >> 1);
    assign rsh = {r_rem[TIME_BITS-1:0], 1'b0};
    assign wr_en   = (r_state == S_IDLE) && i_job_valid && !r_valid &&
                     (i_job.cmd == CMD_APPEND) && (r_count != CNT_BITS'(MAX_POINTS));
    assign wr_addr = r_count[IDX_BITS-1:0];
    assign wr_t    = ((r_count != '0) && (i_job.ptime < r_last)) ? r_last : i_job.ptime;
    assign o_job_ready = (r_state == S_IDLE) && !r_valid;

    always_comb begin
        ma = (r_job.kind == KIND_FADER) ? 17'(i_fmin) :
             (r_job.kind == KIND_PAN)   ? -17'sd256 : 17'(i_amin);
        mb = (r_job.kind == KIND_FADER) ? 17'(i_fmax) :
             (r_job.kind == KIND_PAN)   ? 17'sd256  : 17'(i_amax);
        acc = 37'(signed'({1'b0, r_vlo})) * 37'sd65536 + 37'(r_prod) + 37'sd32768;
        macc_full = 41'(r_a) * 41'sd65536 + 41'(r_macc) + 41'sd32768;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_tmem[wr_addr] <= wr_t;
            r_vmem[wr_addr] <= i_job.pval;
        end
        r_rt <= r_tmem[rd_addr];
        r_rv <= r_vmem[rd_addr];
    end

    always_comb begin
        rd_addr = r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && i_ready) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid && !r_valid) begin
                        r_job   <= i_job;
                        r_full  <= 1'b0;
                        r_empty <= 1'b0;
                        r_level <= '0;
                        r_state <= S_OUT;
                        case (i_job.cmd)
                            CMD_CLEAR: r_count <= '0;
                            CMD_APPEND: begin
                                if (r_count == CNT_BITS'(MAX_POINTS)) r_full <= 1'b1;
                                else begin
                                    r_count <= r_count + 1'b1;
                                    r_last  <= wr_t;
                                end
                            end
                            CMD_EVAL: begin
                                if (r_count == '0) r_empty <= 1'b1;
                                else begin
                                    r_addr  <= '0;
                                    r_state <= S_RD0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD0: begin
                    r_addr  <= IDX_BITS'(r_count - 1'b1);
                    r_first <= 1'b1;
                    r_state <= S_RDL;
                end
                S_RDL: begin
                    // first entry data now arrives
                    r_t0 <= r_rt;
                    r_v0 <= r_rv;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    // last entry data now arrives
                    if (r_job.qtime <= r_t0) begin
                        r_v <= r_v0;
                        r_state <= S_MAP;
                    end else if (r_job.qtime >= r_rt) begin
                        r_v <= r_rv;
                        r_state <= S_MAP;
                    end else begin
                        r_lo <= '0;
                        r_hi <= r_count;
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (r_lo < r_hi) begin
                        r_addr  <= mid[IDX_BITS-1:0];
                        r_state <= S_SRCHW;
                    end else begin
                        // lo is within 1..count-1 here
                        r_addr  <= IDX_BITS'(r_lo - 1'b1);
                        r_state <= S_PAIR;
                    end
                end
                S_SRCHW: begin
                    r_state <= S_PAIRW;
                end
                S_PAIRW: begin
                    if (r_rt < r_job.qtime) r_lo <= mid + 1'b1;
                    else r_hi <= mid;
                    r_state <= S_SRCH;
                end
                S_PAIR: begin
                    r_state <= S_INT;
                    r_first <= 1'b1;
                    r_it    <= '0;
                end
                S_INT: begin
                    if (r_first) begin
                        // lower point arrives; fetch upper
                        r_tlo   <= r_rt;
                        r_vlo   <= r_rv;
                        r_addr  <= r_addr + 1'b1;
                        r_first <= 1'b0;
                    end else if (r_it == '0) begin
                        // upper point read in flight
                        r_it <= 5'd1;
                    end else begin
                        r_state <= S_DIV;
                        r_it    <= '0;
                        if (r_job.kind == KIND_MUTE || r_job.kind == KIND_SOLO) begin
                            r_v <= r_vlo;
                            r_state <= S_MAP;
                        end else if (r_rt <= r_tlo) begin
                            r_v <= r_rv;
                            r_state <= S_MAP;
                        end else begin
                            r_rem <= {1'b0, r_job.qtime - r_tlo};
                            r_den <= r_rt - r_tlo;
                            r_diff <= 18'(signed'({1'b0, r_rv})) -
                                      18'(signed'({1'b0, r_vlo}));
                        end
                    end
                end
                S_DIV: begin
                    if (rsh >= {1'b0, r_den}) begin
                        r_rem <= rsh - {1'b0, r_den};
                        r_f   <= {r_f[14:0], 1'b1};
                    end else begin
                        r_rem <= rsh;
                        r_f   <= {r_f[14:0], 1'b0};
                    end
                    r_it <= r_it + 1'b1;
                    if (r_it == 5'd15) r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= 36'(signed'({1'b0, r_f})) * 36'(r_diff);
                    r_first <= 1'b1;
                    r_state <= S_MAPW;
                end
                S_MAPW: begin
                    if (r_first) begin
                        if (acc < 0) r_v <= '0;
                        else r_v <= VAL_BITS'(acc >>> 16);
                        r_first <= 1'b0;
                    end
                    r_state <= S_MAP;
                end
                S_MAP: begin
                    if (r_v > VAL_BITS'(65536)) r_v <= VAL_BITS'(65536);
                    else begin
                        r_a    <= ma;
                        r_macc <= 35'(signed'({1'b0, r_v})) * 35'(18'(mb) - 18'(ma));
                        r_state <= S_OUT;
                        if (r_job.kind == KIND_MUTE || r_job.kind == KIND_SOLO) begin
                            r_level <= (r_v >= VAL_BITS'(32768)) ? 16'sd256 : 16'sd0;
                            r_job.cmd <= CMD_CLEAR;
                        end else if (r_job.kind[2] && r_v == '0) begin
                            r_level <= i_aoff;
                            r_job.cmd <= CMD_CLEAR;
                        end
                    end
                end
                S_OUT: begin
                    if (r_job.cmd == CMD_EVAL && !r_empty)
                        r_level <= 16'(macc_full >>> 16);
                    r_valid <= 1'b1;
                    r_f     <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_valid;
    assign o_level       = r_level;
    assign o_table_full  = r_full;
    assign o_table_empty = r_empty;
endmodule

### design/automation_envelope_evaluator_top.sv
// ----------------------------------------------------------------------------
// automation_envelope_evaluator_top
// Breakpoint envelope store and evaluator with per-parameter mapping.
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// input   | in        | i_valid / o_ready  | cmd, point_time, point_value, ...
// result  | out       | o_valid / i_ready  | level, table_full, table_empty
// config  | in        | i_cfg_we           | i_cfg_addr, i_cfg_data
//
// Clear and append go straight to the result state in the back end; evaluate
// runs end-point reads, up to 9 search reads of the point memory, a two-read
// fetch of the bracketing pair, a 16-step restoring divider, then one multiply
// each for blend and map. The back end takes no new job while a result waits;
// the two-entry queue then fills and drops o_ready.
// Synchronous active-low reset empties the table.
module automation_envelope_evaluator_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_cmd,
    input  logic [47:0]        i_point_time,
    input  logic [16:0]        i_point_value,
    input  logic [47:0]        i_query_time,
    input  logic [2:0]         i_param_kind,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_level,
    output logic               o_table_full,
    output logic               o_table_empty,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [15:0]        i_cfg_data
);
    import aee_pkg::*;

    t_job               in_job, q_job;
    logic               q_valid, q_ready;
    logic signed [15:0] r_fmin, r_fmax, r_amin, r_amax, r_aoff;

    assign in_job = '{cmd: i_cmd, ptime: i_point_time[TIME_BITS-1:0], pval: i_point_value,
                      qtime: i_query_time[TIME_BITS-1:0], kind: i_param_kind};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmin <= -16'sd15360;
            r_fmax <= 16'sd3072;
            r_amin <= -16'sd15360;
            r_amax <= 16'sd0;
            r_aoff <= -16'sd25600;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_FADER_MIN: r_fmin <= i_cfg_data;
                REG_FADER_MAX: r_fmax <= i_cfg_data;
                REG_AUX_MIN:   r_amin <= i_cfg_data;
                REG_AUX_MAX:   r_amax <= i_cfg_data;
                REG_AUX_OFF:   r_aoff <= i_cfg_data;
                default: ;
            endcase
        end
    end

    aee_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_job(in_job),
        .o_job_valid(q_valid), .i_job_ready(q_ready), .o_job(q_job)
    );

    aee_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(q_valid), .o_job_ready(q_ready), .i_job(q_job),
        .i_fmin(r_fmin), .i_fmax(r_fmax), .i_amin(r_amin), .i_amax(r_amax),
        .i_aoff(r_aoff), .o_valid, .i_ready, .o_level, .o_table_full, .o_table_empty
    );
endmodule

### design/aee_checker.sv
// ----------------------------------------------------------------------------
// aee_checker
// Port-level checks on the envelope evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module aee_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [15:0] o_level,
    input logic               o_table_full,
    input logic               o_table_empty
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_level)) else $error("result dropped");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_table_full && o_table_empty)) else $error("both flags set");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_table_full |-> o_level == 16'sd0) else $error("level on full");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_table_empty |-> o_level == 16'sd0) else $error("level on empty");
endmodule

bind automation_envelope_evaluator_top aee_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_level, .o_table_full, .o_table_empty
);
